// ===== rtl/pt_pkg.sv =====
// pt_pkg: shared types and constants of the presence table with aging
// used by the channel interfaces, the table cells, the report queue and the top level
// no dependencies

package pt_pkg;

    // table geometry and field widths
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int TIME_W        = 32;
    localparam int MAC_W         = 48;
    localparam int LIVES_W       = 4;
    localparam int TIMEOUT_W     = 32;
    localparam int ENTRY_IDX_W   = 4;
    localparam int FUNC_W        = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int CMP_W         = (TIME_W > TIMEOUT_W) ? TIME_W : TIMEOUT_W;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LIVES   = CFG_IDX_W'(1);

    // reset values of the registers
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(30000);
    localparam logic [LIVES_W-1:0]   LIVES_RST   = LIVES_W'(3);

    // item kinds
    typedef enum logic [FUNC_W-1:0] {
        FUNC_SIGHT   = 2'd0,
        FUNC_TICK    = 2'd1,
        FUNC_PRELOAD = 2'd2
    } t_func;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } t_state;

    // token that walks the cell chain with the item
    typedef struct packed {
        logic              active;
        logic [FUNC_W-1:0] func;
        logic [MAC_W-1:0]  mac;
        logic              found;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
    } t_token;

    // one report on its way to the output
    typedef struct packed {
        logic                   valid;
        logic [MAC_W-1:0]       mac;
        logic                   present;
        logic                   observed;
        logic                   full;
        logic [ENTRY_IDX_W-1:0] idx;
    } t_report;

    // write of a new entry into one slot
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [MAC_W-1:0] mac;
        logic             present;
        logic             observed;
    } t_fill;

endpackage

// ===== rtl/pt_if.sv =====
// pt_if: valid/ready channel interfaces of the presence table
// input item channel, report channel and configuration write channel
// depends on pt_pkg

interface pt_item_if;
    import pt_pkg::*;
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [MAC_W-1:0]   mac;

    modport source (output valid, output func, output mac, input ready);
    modport sink   (input valid, input func, input mac, output ready);
endinterface

interface pt_rpt_if;
    import pt_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [MAC_W-1:0]       report_mac;
    logic                   present;
    logic                   observed;
    logic                   table_full;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic                   last;

    modport source (output valid, output report_mac, output present, output observed,
                    output table_full, output entry_index, output last, input ready);
    modport sink   (input valid, input report_mac, input present, input observed,
                    input table_full, input entry_index, input last, output ready);
endinterface

interface pt_cfg_if;
    import pt_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

// ===== rtl/pt_cell.sv =====
// pt_cell: one slot of the presence table and one stage of the token chain
// matches and ages its entry while the token passes and hands the token on; a new entry is filled in from the tail step
// depends on pt_pkg

module pt_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [pt_pkg::IDX_W-1:0]         i_idx,
    input  pt_pkg::t_token                   i_tok,
    input  logic                             i_adv,
    input  logic [pt_pkg::TIME_W-1:0]        i_time,
    input  logic [pt_pkg::TIMEOUT_W-1:0]     i_timeout,
    input  logic [pt_pkg::LIVES_W-1:0]       i_lives,
    input  pt_pkg::t_fill                    i_fill,
    output pt_pkg::t_token                   o_tok,
    output pt_pkg::t_report                  o_rpt
);
    import pt_pkg::*;

    logic               r_valid;
    logic [MAC_W-1:0]   r_addr;
    logic               r_present;
    logic               r_observed;
    logic [TIME_W-1:0]  r_seen;
    logic [LIVES_W-1:0] r_lives;
    t_token             r_tok;

    logic               n_valid;
    logic [MAC_W-1:0]   n_addr;
    logic               n_present;
    logic               n_observed;
    logic [TIME_W-1:0]  n_seen;
    logic [LIVES_W-1:0] n_lives;
    t_token             n_tok;

    logic               w_match;
    logic               w_expired;
    logic [TIME_W-1:0]  w_diff;
    logic               w_commit;
    logic               w_fill_me;

    // entry compare and age test
    assign w_match   = r_valid && (r_addr == i_tok.mac);
    assign w_diff    = i_time - r_seen;
    assign w_expired = r_valid && (CMP_W'(w_diff) > CMP_W'(i_timeout)) && (r_lives != '0);
    assign w_commit  = i_tok.active && i_adv;
    assign w_fill_me = i_fill.en && (i_fill.idx == i_idx);

    // token step, entry update and report
    always_comb begin
        n_tok      = i_tok;
        n_valid    = r_valid;
        n_addr     = r_addr;
        n_present  = r_present;
        n_observed = r_observed;
        n_seen     = r_seen;
        n_lives    = r_lives;
        o_rpt      = '0;
        if (i_tok.active) begin
            case (i_tok.func)
                FUNC_SIGHT: begin
                    if (w_match) begin
                        n_tok.found = 1'b1;
                        n_present   = 1'b1;
                        n_seen      = i_time;
                        n_lives     = i_lives;
                        o_rpt.valid    = 1'b1;
                        o_rpt.mac      = i_tok.mac;
                        o_rpt.present  = 1'b1;
                        o_rpt.observed = r_observed;
                        o_rpt.idx      = ENTRY_IDX_W'(i_idx);
                    end
                    if (!r_valid && !i_tok.free_found) begin
                        n_tok.free_found = 1'b1;
                        n_tok.free_idx   = i_idx;
                    end
                end
                FUNC_TICK: begin
                    if (w_expired) begin
                        n_lives = r_lives - LIVES_W'(1);
                        n_seen  = i_time;
                        if (r_lives == LIVES_W'(1)) begin
                            n_present      = 1'b0;
                            o_rpt.valid    = 1'b1;
                            o_rpt.mac      = r_addr;
                            o_rpt.observed = r_observed;
                            o_rpt.idx      = ENTRY_IDX_W'(i_idx);
                        end
                    end
                end
                FUNC_PRELOAD: begin
                    if (!r_valid && !i_tok.free_found) begin
                        n_tok.free_found = 1'b1;
                        n_tok.free_idx   = i_idx;
                    end
                end
                default: begin
                end
            endcase
        end
        // new entry written at the end of a walk
        if (w_fill_me) begin
            n_valid    = 1'b1;
            n_addr     = i_fill.mac;
            n_present  = i_fill.present;
            n_observed = i_fill.observed;
            n_seen     = i_time;
            n_lives    = i_lives;
        end
    end

    // control: valid bit and token presence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_tok.active <= 1'b0;
        end else begin
            if (w_fill_me) begin
                r_valid <= n_valid;
            end
            if (i_adv) begin
                r_tok.active <= n_tok.active;
            end
        end
    end

    // payload: entry fields and token contents
    always_ff @(posedge i_clk) begin
        if (w_commit || w_fill_me) begin
            r_addr     <= n_addr;
            r_present  <= n_present;
            r_observed <= n_observed;
            r_seen     <= n_seen;
            r_lives    <= n_lives;
        end
        if (i_adv) begin
            r_tok.func       <= n_tok.func;
            r_tok.mac        <= n_tok.mac;
            r_tok.found      <= n_tok.found;
            r_tok.free_found <= n_tok.free_found;
            r_tok.free_idx   <= n_tok.free_idx;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/pt_rptq.sv =====
// pt_rptq: report output stage of the presence table
// holds one report back until the next one or the end of the item decides its last flag
// depends on pt_pkg and pt_if

module pt_rptq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pt_pkg::t_report i_rpt,
    input  logic            i_flush,
    output logic            o_ready,
    pt_rpt_if.source        o_rpt
);
    import pt_pkg::*;

    t_report r_pend;
    t_report r_out;
    logic    r_out_last;
    logic    w_pop;
    logic    w_can_move;

    assign w_pop      = r_out.valid && o_rpt.ready;
    assign w_can_move = !r_out.valid || o_rpt.ready;
    assign o_ready    = !r_pend.valid || w_can_move;

    // control: valid flags of the held and the shown report
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend.valid <= 1'b0;
            r_out.valid  <= 1'b0;
        end else if (i_rpt.valid && o_ready) begin
            r_pend.valid <= 1'b1;
            if (r_pend.valid) begin
                r_out.valid <= 1'b1;
            end else if (w_pop) begin
                r_out.valid <= 1'b0;
            end
        end else if (i_flush && r_pend.valid && w_can_move) begin
            r_pend.valid <= 1'b0;
            r_out.valid  <= 1'b1;
        end else if (w_pop) begin
            r_out.valid <= 1'b0;
        end
    end

    // payload: a held report moves out when a newer one arrives or the item ends
    always_ff @(posedge i_clk) begin
        if (i_rpt.valid && o_ready) begin
            r_pend.mac      <= i_rpt.mac;
            r_pend.present  <= i_rpt.present;
            r_pend.observed <= i_rpt.observed;
            r_pend.full     <= i_rpt.full;
            r_pend.idx      <= i_rpt.idx;
            if (r_pend.valid) begin
                r_out.mac      <= r_pend.mac;
                r_out.present  <= r_pend.present;
                r_out.observed <= r_pend.observed;
                r_out.full     <= r_pend.full;
                r_out.idx      <= r_pend.idx;
                r_out_last     <= 1'b0;
            end
        end else if (i_flush && r_pend.valid && w_can_move) begin
            r_out.mac      <= r_pend.mac;
            r_out.present  <= r_pend.present;
            r_out.observed <= r_pend.observed;
            r_out.full     <= r_pend.full;
            r_out.idx      <= r_pend.idx;
            r_out_last     <= 1'b1;
        end
    end

    assign o_rpt.valid       = r_out.valid;
    assign o_rpt.report_mac  = r_out.mac;
    assign o_rpt.present     = r_out.present;
    assign o_rpt.observed    = r_out.observed;
    assign o_rpt.table_full  = r_out.full;
    assign o_rpt.entry_index = r_out.idx;
    assign o_rpt.last        = r_out_last;

endmodule

// ===== rtl/presence_table_with_aging.sv =====
// Presence table with aging: keeps device addresses with lives and a last-seen time.
// Input channel i_item carries func (sighting, tick, preload) and a 48-bit mac.
// Output channel o_rpt carries one report per matched, sighting-added, expired or dropped
// entry; last marks the final report of an item, items with no report give none.
// Configuration channel i_cfg writes register 0 (timeout_ticks) or 1 (lives_on_sighting);
// writes are always taken, other indexes are ignored, write only while idle.
// An accepted item sends a token down a chain of 16 cells, one cell per cycle unless a
// report stalls it; the tail step adds any new entry and a flush step closes the item.
// The block takes a new item only when idle, after the flush step of the previous one.
// The last report of an item moves from the held register to o_rpt in the flush step.
// A stalled receiver holds the walk whenever a report cannot move out; one report
// waits in the output register and one more is held back for its last flag.
// Reset (i_rst_n low, synchronous) empties the table, clears time and observed-only
// mode and loads timeout 30000 and 3 lives; no clearing pass is needed.
// depends on pt_pkg, pt_if, pt_cell and pt_rptq

module presence_table_with_aging (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pt_item_if.sink    i_item,
    pt_rpt_if.source   o_rpt,
    pt_cfg_if.sink     i_cfg
);
    import pt_pkg::*;

    t_state               r_state;
    t_state               n_state;
    t_token               r_head;
    logic [TIME_W-1:0]    r_time;
    logic                 r_obs_only;
    logic [TIMEOUT_W-1:0] r_timeout;
    logic [LIVES_W-1:0]   r_lives;

    t_token               w_tok [TABLE_ENTRIES+1];
    t_report              w_cell_rpt [TABLE_ENTRIES];
    logic [TABLE_ENTRIES:0] w_act;
    t_report              w_tail_rpt;
    t_report              w_rpt;
    t_fill                w_fill;
    t_token               w_tail;
    logic                 w_accept;
    logic                 w_adv;
    logic                 w_rq_ready;
    logic                 w_flush;
    logic                 w_tail_add;
    logic                 w_tail_done;

    assign w_accept = i_item.valid && i_item.ready;
    assign w_tail   = w_tok[TABLE_ENTRIES];
    assign i_cfg.ready = 1'b1;

    // cell chain
    assign w_tok[0] = r_head;
    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        pt_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_idx     (IDX_W'(k)),
            .i_tok     (w_tok[k]),
            .i_adv     (w_adv),
            .i_time    (r_time),
            .i_timeout (r_timeout),
            .i_lives   (r_lives),
            .i_fill    (w_fill),
            .o_tok     (w_tok[k+1]),
            .o_rpt     (w_cell_rpt[k])
        );
    end

    for (genvar k = 0; k <= TABLE_ENTRIES; k++) begin : g_act
        assign w_act[k] = w_tok[k].active;
    end

    // tail step: add a new entry or report a full table
    always_comb begin
        w_tail_rpt = '0;
        w_fill     = '0;
        w_tail_add = 1'b0;
        if (r_state == ST_WALK && w_tail.active) begin
            case (w_tail.func)
                FUNC_SIGHT:   w_tail_add = !w_tail.found && !r_obs_only;
                FUNC_PRELOAD: w_tail_add = 1'b1;
                default:      w_tail_add = 1'b0;
            endcase
        end
        if (w_tail_add) begin
            if (w_tail.free_found) begin
                w_fill.en       = w_adv;
                w_fill.idx      = w_tail.free_idx;
                w_fill.mac      = w_tail.mac;
                w_fill.present  = (w_tail.func == FUNC_SIGHT);
                w_fill.observed = (w_tail.func == FUNC_PRELOAD);
                if (w_tail.func == FUNC_SIGHT) begin
                    w_tail_rpt.valid   = 1'b1;
                    w_tail_rpt.mac     = w_tail.mac;
                    w_tail_rpt.present = 1'b1;
                    w_tail_rpt.idx     = ENTRY_IDX_W'(w_tail.free_idx);
                end
            end else begin
                w_tail_rpt.valid = 1'b1;
                w_tail_rpt.mac   = w_tail.mac;
                w_tail_rpt.full  = 1'b1;
            end
        end
    end

    // merge reports: at most one source holds the token in a cycle
    always_comb begin
        logic [$bits(t_report)-1:0] v_bits;
        v_bits = w_tail_rpt;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            v_bits = v_bits | w_cell_rpt[k];
        end
        w_rpt = t_report'(v_bits);
    end

    // the chain moves only when a report produced this cycle can be taken
    assign w_adv       = !w_rpt.valid || w_rq_ready;
    assign w_tail_done = (r_state == ST_WALK) && w_tail.active && w_adv;
    assign w_flush     = (r_state == ST_FLUSH);

    pt_rptq u_rptq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rpt   (w_rpt),
        .i_flush (w_flush),
        .o_ready (w_rq_ready),
        .o_rpt   (o_rpt)
    );

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer next state and input ready
    always_comb begin
        n_state      = r_state;
        i_item.ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_item.ready = 1'b1;
                if (i_item.valid) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_tail_done) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (w_rq_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // time, mode, configuration and head token control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time        <= '0;
            r_obs_only    <= 1'b0;
            r_timeout     <= TIMEOUT_RST;
            r_lives       <= LIVES_RST;
            r_head.active <= 1'b0;
        end else begin
            if (w_accept) begin
                r_head.active <= 1'b1;
                if (i_item.func == FUNC_TICK) begin
                    r_time <= r_time + TIME_W'(1);
                end
                if (i_item.func == FUNC_PRELOAD) begin
                    r_obs_only <= 1'b1;
                end
            end else if (w_adv) begin
                r_head.active <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.idx)
                    CFG_TIMEOUT: r_timeout <= i_cfg.data[TIMEOUT_W-1:0];
                    CFG_LIVES:   r_lives   <= i_cfg.data[LIVES_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // head token payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_head.func       <= i_item.func;
            r_head.mac        <= i_item.mac;
            r_head.found      <= 1'b0;
            r_head.free_found <= 1'b0;
            r_head.free_idx   <= '0;
        end
    end

`ifndef SYNTHESIS
    // only one item is ever inside the cell chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_act) <= 1)
        else $error("more than one token in the cell chain");

    // an idle block holds no token
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (w_act == '0))
        else $error("token left in chain while idle");

    // an accepted item starts its walk at the first cell
    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_WALK) && w_act[0])
        else $error("accepted item did not enter the cell chain");

    // a report that is not the last one means its item is still in progress
    a_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rpt.valid && !o_rpt.last) |-> (r_state != ST_IDLE))
        else $error("item closed without a last report");
`endif

endmodule

// ===== sim/tb_presence_table_with_aging.sv =====
// tb_presence_table_with_aging: self-checking bench for the presence table with aging
// sends sightings, ticks and preloads, predicts every report and checks them in order
// depends on pt_pkg, pt_if and presence_table_with_aging

module tb_presence_table_with_aging;
    import pt_pkg::*;

    // codes and limits local to the bench
    localparam logic [FUNC_W-1:0]    FUNC_RSVD     = FUNC_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3   = CFG_IDX_W'(3);
    localparam logic [MAC_W-1:0]     MAC_ONES      = '1;
    localparam int                   SETTLE_CYCLES = 40;
    localparam int                   IDLE_LIMIT    = 2000;
    localparam int                   LONG_HOLD     = 300;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [MAC_W-1:0]  mac;
    } t_tb_item;

    typedef struct packed {
        logic [MAC_W-1:0]       mac;
        logic                   present;
        logic                   observed;
        logic                   full;
        logic [ENTRY_IDX_W-1:0] idx;
        logic                   last;
    } t_tb_report;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    pt_item_if item_ch ();
    pt_rpt_if  rpt_ch ();
    pt_cfg_if  cfg_ch ();

    presence_table_with_aging i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_rpt   (rpt_ch),
        .i_cfg   (cfg_ch)
    );

    // predicted table contents
    logic                 ent_valid    [TABLE_ENTRIES];
    logic [MAC_W-1:0]     ent_mac      [TABLE_ENTRIES];
    logic                 ent_present  [TABLE_ENTRIES];
    logic                 ent_observed [TABLE_ENTRIES];
    logic [TIME_W-1:0]    ent_seen     [TABLE_ENTRIES];
    logic [LIVES_W-1:0]   ent_lives    [TABLE_ENTRIES];
    logic [TIME_W-1:0]    now_time;
    logic                 obs_only;
    logic [TIMEOUT_W-1:0] cur_timeout;
    logic [LIVES_W-1:0]   cur_lives;

    t_tb_item   items_to_send [$];
    t_tb_report reports_due [$];

    int       items_queued = 0;
    int       items_taken  = 0;
    int       mismatches   = 0;
    int       idle_cycles  = 0;
    bit       item_taken_now = 0;
    bit       hold_req = 0;
    int       hold_left = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    int       mode_left = 0;
    int       rx_phase = 0;
    t_rx_mode rx_mode;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        return MAC_W'({$urandom, $urandom});
    endfunction

    function automatic int first_free_slot();
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!ent_valid[i])
                return i;
        end
        return -1;
    endfunction

    function automatic void load_slot(int s, logic [MAC_W-1:0] m, logic pres, logic obs);
        ent_valid[s]    = 1'b1;
        ent_mac[s]      = m;
        ent_present[s]  = pres;
        ent_observed[s] = obs;
        ent_seen[s]     = now_time;
        ent_lives[s]    = cur_lives;
    endfunction

    function automatic void expect_report(logic [MAC_W-1:0] m, logic pres, logic obs,
                                          logic full, int idx);
        t_tb_report r;
        r.mac      = m;
        r.present  = pres;
        r.observed = obs;
        r.full     = full;
        r.idx      = ENTRY_IDX_W'(idx);
        r.last     = 1'b0;
        reports_due.push_back(r);
    endfunction

    // update the predicted table with one item and queue the reports it causes
    function automatic void apply_item(logic [FUNC_W-1:0] f, logic [MAC_W-1:0] m);
        int                s;
        int                queued_before;
        logic              found;
        logic [TIME_W-1:0] age;
        t_tb_report        tail;
        queued_before = reports_due.size();
        found = 1'b0;
        case (f)
            FUNC_SIGHT: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (ent_valid[i] && ent_mac[i] == m) begin
                        ent_present[i] = 1'b1;
                        ent_seen[i]    = now_time;
                        ent_lives[i]   = cur_lives;
                        expect_report(m, 1'b1, ent_observed[i], 1'b0, i);
                        found = 1'b1;
                    end
                end
                if (!found && !obs_only) begin
                    s = first_free_slot();
                    if (s < 0) begin
                        expect_report(m, 1'b0, 1'b0, 1'b1, 0);
                    end else begin
                        load_slot(s, m, 1'b1, 1'b0);
                        expect_report(m, 1'b1, 1'b0, 1'b0, s);
                    end
                end
            end
            FUNC_TICK: begin
                now_time = now_time + 1'b1;
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (ent_valid[i]) begin
                        age = now_time - ent_seen[i];
                        // stale entries lose a life; an entry at zero lives stays put
                        if (age > cur_timeout && ent_lives[i] != '0) begin
                            ent_lives[i] = ent_lives[i] - 1'b1;
                            ent_seen[i]  = now_time;
                            if (ent_lives[i] == '0) begin
                                ent_present[i] = 1'b0;
                                expect_report(ent_mac[i], 1'b0, ent_observed[i], 1'b0, i);
                            end
                        end
                    end
                end
            end
            FUNC_PRELOAD: begin
                obs_only = 1'b1;
                s = first_free_slot();
                if (s < 0)
                    expect_report(m, 1'b0, 1'b0, 1'b1, 0);
                else
                    load_slot(s, m, 1'b0, 1'b1);
            end
            default: begin
            end
        endcase
        // flag the final report of this item
        if (reports_due.size() > queued_before) begin
            tail = reports_due.pop_back();
            tail.last = 1'b1;
            reports_due.push_back(tail);
        end
    endfunction

    task automatic log_mismatch(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send(logic [FUNC_W-1:0] f, logic [MAC_W-1:0] m);
        t_tb_item it;
        it.func = f;
        it.mac  = m;
        items_to_send.push_back(it);
        items_queued++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.idx   <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        case (idx)
            CFG_TIMEOUT: cur_timeout = data;
            CFG_LIVES:   cur_lives = data[LIVES_W-1:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait until every item is taken and every report is back, then let the walk finish
    task automatic wait_idle();
        @(negedge i_clk);
        while (items_taken != items_queued || reports_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // acceptance, report check and watchdog
    always @(posedge i_clk) begin
        t_tb_report want;
        bit         moved;
        item_taken_now = 1'b0;
        moved = 1'b0;
        if (i_rst_n) begin
            if (item_ch.valid && item_ch.ready) begin
                item_taken_now = 1'b1;
                moved = 1'b1;
                items_taken++;
                apply_item(item_ch.func, item_ch.mac);
            end
            if (rpt_ch.valid && rpt_ch.ready) begin
                moved = 1'b1;
                if (reports_due.size() == 0) begin
                    log_mismatch($sformatf("unexpected report for mac %h", rpt_ch.report_mac));
                end else begin
                    want = reports_due.pop_front();
                    if (rpt_ch.report_mac !== want.mac)
                        log_mismatch($sformatf("report_mac %h, expected %h",
                                               rpt_ch.report_mac, want.mac));
                    if (rpt_ch.present !== want.present)
                        log_mismatch($sformatf("present %b, expected %b for mac %h",
                                               rpt_ch.present, want.present, want.mac));
                    if (rpt_ch.observed !== want.observed)
                        log_mismatch($sformatf("observed %b, expected %b for mac %h",
                                               rpt_ch.observed, want.observed, want.mac));
                    if (rpt_ch.table_full !== want.full)
                        log_mismatch($sformatf("table_full %b, expected %b for mac %h",
                                               rpt_ch.table_full, want.full, want.mac));
                    if (rpt_ch.entry_index !== want.idx)
                        log_mismatch($sformatf("entry_index %0d, expected %0d for mac %h",
                                               rpt_ch.entry_index, want.idx, want.mac));
                    if (rpt_ch.last !== want.last)
                        log_mismatch($sformatf("last %b, expected %b for mac %h",
                                               rpt_ch.last, want.last, want.mac));
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
                moved = 1'b1;
        end
        if (moved)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // item driver: bursts of random length with random gaps
    always @(negedge i_clk) begin
        t_tb_item next_item;
        if (!item_ch.valid || item_taken_now) begin
            if (gap_left > 0) begin
                item_ch.valid <= 1'b0;
                gap_left--;
            end else if (items_to_send.size() != 0) begin
                next_item = items_to_send.pop_front();
                item_ch.valid <= 1'b1;
                item_ch.func  <= next_item.func;
                item_ch.mac   <= next_item.mac;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                end
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // report receiver: changing stall patterns, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            rpt_ch.ready <= 1'b0;
            hold_left--;
        end else begin
            if (mode_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            rx_phase++;
            case (rx_mode)
                RX_OPEN:   rpt_ch.ready <= 1'b1;
                RX_COIN:   rpt_ch.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: rpt_ch.ready <= (rx_phase % 4 == 0);
                default:   rpt_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // stimulus
    initial begin
        logic [MAC_W-1:0] pool [7];
        int               n;
        int               r;
        item_ch.valid = 1'b0;
        item_ch.func  = '0;
        item_ch.mac   = '0;
        rpt_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.idx    = '0;
        cfg_ch.data   = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            ent_valid[i]    = 1'b0;
            ent_mac[i]      = '0;
            ent_present[i]  = 1'b0;
            ent_observed[i] = 1'b0;
            ent_seen[i]     = '0;
            ent_lives[i]    = '0;
        end
        now_time    = '0;
        obs_only    = 1'b0;
        cur_timeout = TIMEOUT_RST;
        cur_lives   = LIVES_RST;

        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: adds, a repeat sighting, an idle tick, the unused code
        send(FUNC_SIGHT, '0);
        send(FUNC_SIGHT, MAC_ONES);
        send(FUNC_SIGHT, '0);
        send(FUNC_TICK, rand_mac());
        send(FUNC_RSVD, rand_mac());
        send(FUNC_SIGHT, 48'hAAAA_5555_AAAA);
        wait_idle();

        // timeout 1 and one life: entries run out of lives, then sit at zero
        write_reg(CFG_TIMEOUT, 1);
        write_reg(CFG_LIVES, 1);
        repeat (8) send(FUNC_TICK, rand_mac());
        send(FUNC_SIGHT, MAC_ONES);
        repeat (3) send(FUNC_TICK, rand_mac());
        wait_idle();

        // zero timeout and zero lives: loaded entries never age; spare indexes ignored
        write_reg(CFG_TIMEOUT, 0);
        write_reg(CFG_LIVES, 0);
        write_reg(CFG_SPARE_2, $urandom);
        write_reg(CFG_SPARE_3, $urandom);
        send(FUNC_SIGHT, 48'h0123_4567_89AB);
        repeat (2) send(FUNC_TICK, rand_mac());
        send(FUNC_SIGHT, '0);
        send(FUNC_TICK, rand_mac());
        wait_idle();

        // sightings over a small address pool with aging, table not yet full
        pool[0] = '0;
        pool[1] = MAC_ONES;
        pool[2] = 48'hAAAA_5555_AAAA;
        pool[3] = 48'h0123_4567_89AB;
        for (int i = 4; i < 7; i++)
            pool[i] = rand_mac();
        write_reg(CFG_TIMEOUT, 2);
        write_reg(CFG_LIVES, 2);
        for (n = 0; n < 60; n++) begin
            if (n == 30) begin
                // receiver holds off while items keep coming, then everything drains
                hold_req = 1'b1;
                wait_idle();
            end
            r = $urandom_range(0, 99);
            if (r < 60)
                send(FUNC_SIGHT, pool[$urandom_range(0, 6)]);
            else if (r < 92)
                send(FUNC_TICK, rand_mac());
            else
                send(FUNC_RSVD, rand_mac());
        end
        wait_idle();

        // preloads: duplicates, observed-only mode, then overflow of the table
        write_reg(CFG_TIMEOUT, 3);
        write_reg(CFG_LIVES, 2);
        send(FUNC_PRELOAD, pool[0]);
        send(FUNC_PRELOAD, pool[1]);
        send(FUNC_PRELOAD, pool[2]);
        send(FUNC_SIGHT, pool[0]);
        send(FUNC_SIGHT, rand_mac());
        send(FUNC_TICK, rand_mac());
        repeat (11) send(FUNC_PRELOAD, rand_mac());
        send(FUNC_SIGHT, pool[1]);
        wait_idle();

        // stamp every entry at once so that the whole table ages out on a single tick
        write_reg(CFG_TIMEOUT, 1);
        write_reg(CFG_LIVES, 1);
        for (n = 0; n < TABLE_ENTRIES; n++)
            send(FUNC_SIGHT, ent_mac[n]);
        repeat (2) send(FUNC_TICK, rand_mac());
        wait_idle();

        // random traffic on the full table under three settings
        for (n = 0; n < 3; n++) begin
            case (n)
                0: begin
                    write_reg(CFG_TIMEOUT, 1);
                    write_reg(CFG_LIVES, 15);
                end
                1: begin
                    write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
                    write_reg(CFG_LIVES, $urandom_range(1, 14));
                end
                default: begin
                    write_reg(CFG_TIMEOUT, $urandom_range(2, 6));
                    write_reg(CFG_LIVES, 1);
                end
            endcase
            repeat (80) begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    send(FUNC_SIGHT, ent_mac[$urandom_range(0, TABLE_ENTRIES - 1)]);
                else if (r < 65)
                    send(FUNC_SIGHT, rand_mac());
                else if (r < 90)
                    send(FUNC_TICK, rand_mac());
                else if (r < 95)
                    send(FUNC_PRELOAD, rand_mac());
                else
                    send(FUNC_RSVD, rand_mac());
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
